>>> hw/rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

   // Error codes carried with each result.
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_LEAD  = 3'd1,
      ERR_TRUNCATED = 3'd2,
      ERR_BAD_CONT  = 3'd3,
      ERR_BAD_POINT = 3'd4
   } err_kind_type;

   localparam int unsigned POINT_W   = 21;
   localparam int unsigned UNIT_W    = 16;
   localparam int unsigned REQ_TDATA_W = 16;

   localparam logic [POINT_W-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [POINT_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [POINT_W-1:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [POINT_W-1:0] MAX_POINT      = 21'h10FFFF;
   localparam logic [POINT_W-1:0] SURR_LOW_BOUND = 21'h00D800;
   localparam logic [POINT_W-1:0] SURR_HIGH_BOUND = 21'h00DFFF;
   localparam logic [POINT_W-1:0] BMP_MAX        = 21'h00FFFF;
   localparam logic [POINT_W-1:0] PLANE1_BASE    = 21'h010000;

   // Top six bits of high and low surrogates.
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   // One result item.
   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      err_kind_type      error_kind;
      logic              last_of_run;
   } result_type;

endpackage

>>> hw/rtl/utf8_to_utf16_decoder_unit.sv
// UTF-8 to UTF-16 decoder: input register, decode logic, two-slot result register.
//
//  channel | dir | ports      | payload
//  --------+-----+------------+--------------------------------------------------
//  req     | in  | req_t*     | tdata[7:0] byte_value, tdata[9:8] bytes_after
//  rsp     | out | rsp_t*     | tdata code_unit, tuser error_kind, tlast last_of_run
//
// One request per cycle is taken while the result register can accept the decode
// of the byte before it. A request that decodes to a code point above 0xFFFF yields
// two results (high then low surrogate); the next request waits in the input
// register until the low surrogate is being taken. Decode runs in the cycle a request
// leaves the input register; a result shows on rsp the following cycle.
// reset (synchronous, active high) clears decoder state and empties both stages.
// A stall on rsp backs up through the result slots into the input register and
// then drops req_tready; rsp_tready reaches req_tready combinationally.
module utf8_to_utf16_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] byte_value, [9:8] bytes_after, rest zero
   // result side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [2:0]  rsp_tuser,   // [2:0] error_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int unsigned PW = u8u16_pkg::POINT_W;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [1:0] in_after_ff, in_after_in;

   // decoder state
   logic [PW-1:0] partial_point_ff, partial_point_in;
   logic [1:0]    pending_count_ff, pending_count_in;
   logic [1:0]    sequence_length_ff, sequence_length_in;
   logic          skipping_ff, skipping_in;

   // result register: slot 0 is shown, slot 1 waits behind it
   logic [1:0]             res_count_ff, res_count_in;
   u8u16_pkg::result_type  res0_ff, res0_in;
   u8u16_pkg::result_type  res1_ff, res1_in;

   // decode outputs
   logic [1:0]             dec_count;
   u8u16_pkg::result_type  dec_r0, dec_r1;
   logic [PW-1:0]          dec_point;
   logic [1:0]             dec_pending;
   logic [1:0]             dec_seqlen;
   logic                   dec_skip;

   logic          res_pop;
   logic          res_free;
   logic          dec_go;
   logic [PW-1:0] cp_next;
   logic [PW-1:0] cp_min;
   logic [PW-1:0] cp_off;
   logic [1:0]    pend_next;
   logic [PW-1:0] lead_bits;
   logic [1:0]    lead_tail;
   logic          lead_bad;

   assign res_pop  = rsp_tvalid && rsp_tready;
   // result register is empty after this edge
   assign res_free = (res_count_ff == 2'd0) || ((res_count_ff == 2'd1) && rsp_tready);
   assign dec_go   = in_valid_ff && res_free;
   assign req_tready = !in_valid_ff || dec_go;

   assign rsp_tvalid = (res_count_ff != 2'd0);
   assign rsp_tdata  = res0_ff.code_unit;
   assign rsp_tuser  = res0_ff.error_kind;
   assign rsp_tlast  = res0_ff.last_of_run;

   // lead byte class
   always_comb begin
      lead_bits = '0;
      lead_tail = 2'd0;
      lead_bad  = 1'b0;
      case (in_byte_ff) inside
         [8'hC0:8'hDF]: begin
            lead_bits = PW'(in_byte_ff[4:0]);
            lead_tail = 2'd1;
         end
         [8'hE0:8'hEF]: begin
            lead_bits = PW'(in_byte_ff[3:0]);
            lead_tail = 2'd2;
         end
         [8'hF0:8'hF7]: begin
            lead_bits = PW'(in_byte_ff[2:0]);
            lead_tail = 2'd3;
         end
         default: begin
            lead_bad = 1'b1;
         end
      endcase
   end

   assign cp_next   = {partial_point_ff[PW-7:0], in_byte_ff[5:0]};
   assign pend_next = pending_count_ff - 2'd1;
   assign cp_off    = cp_next - u8u16_pkg::PLANE1_BASE;

   always_comb begin
      case (sequence_length_ff)
         2'd1:    cp_min = u8u16_pkg::MIN_TWO_BYTE;
         2'd2:    cp_min = u8u16_pkg::MIN_THREE_BYTE;
         default: cp_min = u8u16_pkg::MIN_FOUR_BYTE;
      endcase
   end

   // decode one byte against the current state
   always_comb begin
      dec_count   = 2'd0;
      dec_r0      = '{code_unit: '0, error_kind: u8u16_pkg::ERR_NONE, last_of_run: 1'b1};
      dec_r1      = '{code_unit: '0, error_kind: u8u16_pkg::ERR_NONE, last_of_run: 1'b1};
      dec_point   = partial_point_ff;
      dec_pending = pending_count_ff;
      dec_seqlen  = sequence_length_ff;
      dec_skip    = skipping_ff;

      if (skipping_ff) begin
         // drop bytes until the string ends
         if (in_after_ff == 2'd0) begin
            dec_skip = 1'b0;
         end
      end else if (pending_count_ff == 2'd0) begin
         if (!in_byte_ff[7]) begin
            dec_count        = 2'd1;
            dec_r0.code_unit = {8'h00, in_byte_ff};
         end else if (lead_bad) begin
            dec_count         = 2'd1;
            dec_r0.error_kind = u8u16_pkg::ERR_BAD_LEAD;
            dec_skip          = (in_after_ff != 2'd0);
         end else if (lead_tail > in_after_ff) begin
            dec_count         = 2'd1;
            dec_r0.error_kind = u8u16_pkg::ERR_TRUNCATED;
            dec_skip          = (in_after_ff != 2'd0);
         end else begin
            dec_point   = lead_bits;
            dec_pending = lead_tail;
            dec_seqlen  = lead_tail;
         end
      end else if (in_byte_ff[7:6] != 2'b10) begin
         dec_count         = 2'd1;
         dec_r0.error_kind = u8u16_pkg::ERR_BAD_CONT;
         dec_point         = '0;
         dec_pending       = 2'd0;
         dec_seqlen        = 2'd0;
         dec_skip          = (in_after_ff != 2'd0);
      end else if (pend_next != 2'd0) begin
         if (in_after_ff == 2'd0) begin
            // string ends inside a sequence
            dec_count         = 2'd1;
            dec_r0.error_kind = u8u16_pkg::ERR_TRUNCATED;
            dec_point         = '0;
            dec_pending       = 2'd0;
            dec_seqlen        = 2'd0;
         end else begin
            dec_point   = cp_next;
            dec_pending = pend_next;
         end
      end else begin
         dec_point   = '0;
         dec_pending = 2'd0;
         dec_seqlen  = 2'd0;
         if ((cp_next < cp_min) || (cp_next > u8u16_pkg::MAX_POINT) ||
             ((cp_next >= u8u16_pkg::SURR_LOW_BOUND) &&
              (cp_next <= u8u16_pkg::SURR_HIGH_BOUND))) begin
            dec_count         = 2'd1;
            dec_r0.error_kind = u8u16_pkg::ERR_BAD_POINT;
            dec_skip          = (in_after_ff != 2'd0);
         end else if (cp_next <= u8u16_pkg::BMP_MAX) begin
            dec_count        = 2'd1;
            dec_r0.code_unit = cp_next[15:0];
         end else begin
            // surrogate pair
            dec_count          = 2'd2;
            dec_r0.code_unit   = {u8u16_pkg::HIGH_SURR_TAG, cp_off[19:10]};
            dec_r0.last_of_run = 1'b0;
            dec_r1.code_unit   = {u8u16_pkg::LOW_SURR_TAG, cp_off[9:0]};
         end
      end
   end

   // next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_after_in = in_after_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata[7:0];
         in_after_in = req_tdata[9:8];
      end else if (dec_go) begin
         in_valid_in = 1'b0;
      end

      partial_point_in   = partial_point_ff;
      pending_count_in   = pending_count_ff;
      sequence_length_in = sequence_length_ff;
      skipping_in        = skipping_ff;
      if (dec_go) begin
         partial_point_in   = dec_point;
         pending_count_in   = dec_pending;
         sequence_length_in = dec_seqlen;
         skipping_in        = dec_skip;
      end

      res_count_in = res_count_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      if (dec_go) begin
         res_count_in = dec_count;
         res0_in      = dec_r0;
         res1_in      = dec_r1;
      end else if (res_pop) begin
         res_count_in = res_count_ff - 2'd1;
         res0_in      = res1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         partial_point_ff   <= '0;
         pending_count_ff   <= 2'd0;
         sequence_length_ff <= 2'd0;
         skipping_ff        <= 1'b0;
         res_count_ff       <= 2'd0;
      end else begin
         in_valid_ff        <= in_valid_in;
         partial_point_ff   <= partial_point_in;
         pending_count_ff   <= pending_count_in;
         sequence_length_ff <= sequence_length_in;
         skipping_ff        <= skipping_in;
         res_count_ff       <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_after_ff <= in_after_in;
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
   end

endmodule

>>> hw/rtl/u8u16_checker.sv
// Port-level assertions for the UTF-8 to UTF-16 decoder, bound to the top level.
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // nothing shows right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an error result has a zero unit and closes its request
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != u8u16_pkg::ERR_NONE)) |-> (rsp_tdata == 16'h0000) && rsp_tlast)
      else $error("error result with nonzero unit or without tlast");

   // only a high surrogate is followed by another result of the same request
   a_open_is_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |->
         (rsp_tdata[15:10] == u8u16_pkg::HIGH_SURR_TAG) && (rsp_tuser == u8u16_pkg::ERR_NONE))
      else $error("non-final result is not a high surrogate");

   // low surrogate follows a taken high surrogate at once
   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tlast && (rsp_tdata[15:10] == u8u16_pkg::LOW_SURR_TAG)))
      else $error("low surrogate missing after high surrogate");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_u8u16_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/utf8_to_utf16_decoder_unit_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder unit.
module utf8_to_utf16_decoder_unit_test;

   localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with work pending but no handshake
   localparam int unsigned RANDOM_BYTES   = 1500;  // throttled random strings
   localparam int unsigned STEADY_BYTES   = 400;   // back-to-back stretch, no idling
   localparam int unsigned DRAIN_CYCLES   = 10;    // settle time after the last result

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] byte_value, [9:8] bytes_after, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] code_unit
   logic [2:0]  rsp_tuser;         // [2:0] error_kind
   logic        rsp_tlast;         // last_of_run

   // Decoder state as the checker sees it.
   logic [u8u16_pkg::POINT_W-1:0] dec_partial  = '0;
   logic [1:0]                    dec_pending  = '0;
   logic [1:0]                    dec_seq_len  = '0;
   logic                          dec_skipping = 1'b0;

   u8u16_pkg::result_type expected_units[$];   // code units still owed by the decoder
   logic [7:0]  text_bytes[$];       // UTF-8 string being built
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   bit          throttle_on    = 1'b1;

   utf8_to_utf16_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // Expected-result bookkeeping
   // ---------------------------------------------------------------
   function automatic void expect_unit(logic [15:0] unit, u8u16_pkg::err_kind_type kind,
                                       logic last);
      u8u16_pkg::result_type r;
      r.code_unit   = unit;
      r.error_kind  = kind;
      r.last_of_run = last;
      expected_units.insert(expected_units.size(), r);
   endfunction

   // Append one byte to the string under construction.
   function automatic void add_text_byte(logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   // An error clears the sequence; skip the rest of the string unless this was its end.
   function automatic void decode_fail(u8u16_pkg::err_kind_type kind, logic [1:0] after);
      dec_partial  = '0;
      dec_pending  = '0;
      dec_seq_len  = '0;
      dec_skipping = (after != 2'd0);
      expect_unit(16'h0000, kind, 1'b1);
   endfunction

   // Advance the decoder by one accepted byte and queue what it must emit.
   function automatic void decode_byte(logic [7:0] b, logic [1:0] after);
      logic [u8u16_pkg::POINT_W-1:0] point;
      logic [u8u16_pkg::POINT_W-1:0] floor_pt;
      logic [u8u16_pkg::POINT_W-1:0] offset;
      logic [1:0]                    tail;
      if (dec_skipping) begin
         if (after == 2'd0) dec_skipping = 1'b0;
         return;
      end
      if (dec_pending == 2'd0) begin
         // ASCII goes straight out, bytes_after is irrelevant here
         if (b[7] == 1'b0) begin
            expect_unit({8'h00, b}, u8u16_pkg::ERR_NONE, 1'b1);
            return;
         end else if (b[7:5] == 3'b110) begin
            point = {16'd0, b[4:0]};
            tail  = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            point = {17'd0, b[3:0]};
            tail  = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            point = {18'd0, b[2:0]};
            tail  = 2'd3;
         end else begin
            decode_fail(u8u16_pkg::ERR_BAD_LEAD, after);
            return;
         end
         // lead announces more bytes than the string still holds
         if (tail > after) begin
            decode_fail(u8u16_pkg::ERR_TRUNCATED, after);
            return;
         end
         dec_partial = point;
         dec_pending = tail;
         dec_seq_len = tail;
         return;
      end
      if (b[7:6] != 2'b10) begin
         decode_fail(u8u16_pkg::ERR_BAD_CONT, after);
         return;
      end
      dec_partial = {dec_partial[u8u16_pkg::POINT_W-7:0], b[5:0]};
      dec_pending = dec_pending - 2'd1;
      if (dec_pending != 2'd0) begin
         // string ended in the middle of a sequence
         if (after == 2'd0) decode_fail(u8u16_pkg::ERR_TRUNCATED, after);
         return;
      end
      point = dec_partial;
      case (dec_seq_len)
         2'd1:    floor_pt = u8u16_pkg::MIN_TWO_BYTE;
         2'd2:    floor_pt = u8u16_pkg::MIN_THREE_BYTE;
         default: floor_pt = u8u16_pkg::MIN_FOUR_BYTE;
      endcase
      dec_partial = '0;
      dec_seq_len = '0;
      if (point < floor_pt || point > u8u16_pkg::MAX_POINT ||
          (point >= u8u16_pkg::SURR_LOW_BOUND && point <= u8u16_pkg::SURR_HIGH_BOUND)) begin
         decode_fail(u8u16_pkg::ERR_BAD_POINT, after);
      end else if (point <= u8u16_pkg::BMP_MAX) begin
         expect_unit(point[15:0], u8u16_pkg::ERR_NONE, 1'b1);
      end else begin
         offset = point - u8u16_pkg::PLANE1_BASE;
         expect_unit({u8u16_pkg::HIGH_SURR_TAG, offset[19:10]}, u8u16_pkg::ERR_NONE, 1'b0);
         expect_unit({u8u16_pkg::LOW_SURR_TAG, offset[9:0]}, u8u16_pkg::ERR_NONE, 1'b1);
      end
   endfunction

   // ---------------------------------------------------------------
   // Request driver: one byte per call. tvalid is left high after the
   // handshake so back-to-back bytes never toggle it within one step.
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic [1:0] after);
      if (throttle_on && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, after, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, after);
   endtask

   // ---------------------------------------------------------------
   // Result side: random backpressure, then compare with the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= !(throttle_on && $urandom_range(0, 99) < 20);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      u8u16_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_units.size() == 0) begin
            report_mismatch("result with none pending, code_unit", 32'(rsp_tdata), 32'd0);
         end else begin
            want = expected_units.pop_front();
            if (rsp_tdata !== want.code_unit)
               report_mismatch("code_unit", 32'(rsp_tdata), 32'(want.code_unit));
            if (rsp_tuser !== want.error_kind)
               report_mismatch("error_kind", 32'(rsp_tuser), 32'(want.error_kind));
            if (rsp_tlast !== want.last_of_run)
               report_mismatch("last_of_run", 32'(rsp_tlast), 32'(want.last_of_run));
         end
      end
   end

   // Watchdog: stuck handshakes while something is still owed.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (req_tvalid || expected_units.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Well-formed strings at the edges of each sequence length.
   task automatic test_valid_sequences();
      send_byte(8'h00, 2'd3);                        // ASCII while idle, more bytes follow
      send_byte(8'hC2, 2'd1); send_byte(8'h80, 2'd0); // U+0080, smallest two-byte
      send_byte(8'hEF, 2'd2); send_byte(8'hBF, 2'd1); send_byte(8'hBF, 2'd0); // U+FFFF
      send_byte(8'hF4, 2'd3); send_byte(8'h8F, 2'd2); // U+10FFFF, surrogate pair
      send_byte(8'hBF, 2'd1); send_byte(8'hBF, 2'd0);
   endtask

   // At least one string per error kind, with and without the skip that follows.
   task automatic test_error_cases();
      send_byte(8'hFF, 2'd0);                         // bad lead on last byte: no skip
      send_byte(8'hE2, 2'd1); send_byte(8'h41, 2'd0); // lead too long for string, then skip
      send_byte(8'hE2, 2'd2); send_byte(8'h82, 2'd0); // string ends inside a sequence
      send_byte(8'hC3, 2'd2); send_byte(8'h41, 2'd1); // bad continuation, skip to end
      send_byte(8'h42, 2'd0);
      send_byte(8'hC0, 2'd1); send_byte(8'h80, 2'd0); // overlong
      send_byte(8'hED, 2'd2); send_byte(8'hA0, 2'd1); // surrogate code point
      send_byte(8'h80, 2'd0);
      send_byte(8'hF4, 2'd3); send_byte(8'h90, 2'd2); // above U+10FFFF
      send_byte(8'h80, 2'd1); send_byte(8'h80, 2'd0);
   endtask

   // Mostly well-formed strings with random code points, some corrupted,
   // plus a share of raw noise with arbitrary bytes_after.
   task automatic test_random_strings(input int unsigned byte_budget);
      int unsigned sent;
      int          n_points;
      int          len;
      int          pick;
      int          cut;
      int          remaining;
      logic [20:0] p;
      sent = 0;
      while (sent < byte_budget) begin
         if ($urandom_range(0, 9) == 0) begin
            n_points = $urandom_range(1, 8);
            for (int i = 0; i < n_points; i++)
               send_byte(8'($urandom), (i == n_points - 1) ? 2'd0 : 2'($urandom));
            sent += n_points;
         end else begin
            text_bytes.delete();
            n_points = $urandom_range(1, 6);
            for (int i = 0; i < n_points; i++) begin
               pick = $urandom_range(0, 9);
               case (pick)
                  0, 1, 2: begin p = 21'($urandom_range(0, 'h7F));       len = 1; end
                  3, 4:    begin p = 21'($urandom_range('h80, 'h7FF));   len = 2; end
                  5, 6:    begin p = 21'($urandom_range('h800, 'hFFFF)); len = 3; end
                  7, 8:    begin p = 21'($urandom_range('h10000, 'h10FFFF)); len = 4; end
                  default: begin
                     case ($urandom_range(0, 2))
                        0: begin   // overlong form
                           len = $urandom_range(2, 4);
                           if (len == 2)      p = 21'($urandom_range(0, 'h7F));
                           else if (len == 3) p = 21'($urandom_range(0, 'h7FF));
                           else               p = 21'($urandom_range(0, 'hFFFF));
                        end
                        1: begin p = 21'($urandom_range('hD800, 'hDFFF)); len = 3; end
                        default: begin p = 21'($urandom_range('h110000, 'h1FFFFF)); len = 4; end
                     endcase
                  end
               endcase
               case (len)
                  1: add_text_byte({1'b0, p[6:0]});
                  2: begin
                     add_text_byte({3'b110, p[10:6]});
                     add_text_byte({2'b10, p[5:0]});
                  end
                  3: begin
                     add_text_byte({4'b1110, p[15:12]});
                     add_text_byte({2'b10, p[11:6]});
                     add_text_byte({2'b10, p[5:0]});
                  end
                  default: begin
                     add_text_byte({5'b11110, p[20:18]});
                     add_text_byte({2'b10, p[17:12]});
                     add_text_byte({2'b10, p[11:6]});
                     add_text_byte({2'b10, p[5:0]});
                  end
               endcase
            end
            // corrupt a byte or cut the tail now and then
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
            end else if (pick < 18 && text_bytes.size() > 1) begin
               cut = $urandom_range(1, text_bytes.size() - 1);
               repeat (cut) void'(text_bytes.pop_back());
            end
            foreach (text_bytes[i]) begin
               remaining = text_bytes.size() - 1 - i;
               send_byte(text_bytes[i], (remaining > 3) ? 2'd3 : 2'(remaining));
            end
            sent += text_bytes.size();
         end
      end
   endtask

   // Full-rate stretch: no gaps on requests, no stalls on results.
   task automatic test_back_to_back();
      throttle_on <= 1'b0;
      test_random_strings(STEADY_BYTES);
      throttle_on <= 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_valid_sequences();
      test_error_cases();
      test_random_strings(RANDOM_BYTES);
      test_back_to_back();
      req_tvalid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
